### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/mpd_pkg.sv
// ---------------------------------------------------------------------------
// mpd_pkg
// types and codes shared by the mqtt packet deframer files
// ---------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

    localparam int unsigned LEN_W = 28;

    // byte role codes
    localparam logic [2:0] ROLE_TYPE       = 3'd0;
    localparam logic [2:0] ROLE_LENGTH     = 3'd1;
    localparam logic [2:0] ROLE_TOPIC_SIZE = 3'd2;
    localparam logic [2:0] ROLE_TOPIC      = 3'd3;
    localparam logic [2:0] ROLE_PAYLOAD    = 3'd4;
    localparam logic [2:0] ROLE_OTHER      = 3'd5;

    localparam logic [3:0] KIND_PUBLISH    = 4'd3;

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 28'd2048;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] byte_role;
        logic [3:0] packet_kind;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       publish_valid;
        logic       oversize;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/mpd_parser.sv
// ---------------------------------------------------------------------------
// mpd_parser
// per-byte header/body state machine; result is combinational from the byte
// ---------------------------------------------------------------------------
`default_nettype none

module mpd_parser import mpd_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic [LEN_W-1:0] i_max_body_length,
    output t_result               o_result
);

    typedef enum logic [2:0] {
        PH_TYPE, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_PAYLOAD, PH_OTHER
    } t_phase;

    localparam logic [2:0] LEN_BYTES = 3'(MAX_LENGTH_BYTES);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_kind, n_kind;
    logic [LEN_W-1:0] r_accum, n_accum;
    logic [2:0]       r_len_cnt, n_len_cnt;
    logic [LEN_W-1:0] r_body_left, n_body_left;
    logic [15:0]      r_topic_size, n_topic_size;
    logic [15:0]      r_topic_left, n_topic_left;
    logic             r_bad, n_bad;

    logic [LEN_W-1:0] len_group;
    logic [LEN_W-1:0] body_rem;
    logic             over_now;

    // 7-bit group placed at its offset
    always_comb begin
        unique case (r_len_cnt[1:0])
            2'd0:    len_group = {21'd0, i_byte[6:0]};
            2'd1:    len_group = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_group = {7'd0, i_byte[6:0], 14'd0};
            default: len_group = {i_byte[6:0], 21'd0};
        endcase
    end

    assign body_rem = (r_body_left != '0) ? r_body_left - 28'd1 : '0;
    assign over_now = (r_accum > i_max_body_length);

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_accum      = r_accum;
        n_len_cnt    = r_len_cnt;
        n_body_left  = r_body_left;
        n_topic_size = r_topic_size;
        n_topic_left = r_topic_left;
        n_bad        = r_bad;

        o_result.data_byte       = i_byte;
        o_result.byte_role       = ROLE_TYPE;
        o_result.first_of_packet = 1'b0;
        o_result.last_of_packet  = 1'b0;
        o_result.publish_valid   = 1'b0;
        o_result.oversize        = 1'b0;

        unique case (r_phase)
            PH_LEN: begin
                o_result.byte_role = ROLE_LENGTH;
                n_accum   = r_accum | len_group;
                n_len_cnt = r_len_cnt + 3'd1;
                if (!i_byte[7] || (n_len_cnt >= LEN_BYTES)) begin
                    o_result.oversize = (n_accum > i_max_body_length);
                    if (n_accum == '0) begin
                        o_result.last_of_packet = 1'b1;
                        n_phase = PH_TYPE;
                    end else begin
                        n_body_left = n_accum;
                        n_phase = (r_kind == KIND_PUBLISH) ? PH_TLEN_HI : PH_OTHER;
                    end
                end
            end
            PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_PAYLOAD, PH_OTHER: begin
                n_body_left = body_rem;
                o_result.oversize       = over_now;
                o_result.last_of_packet = (body_rem == '0);
                unique case (r_phase)
                    PH_TLEN_HI: begin
                        o_result.byte_role = ROLE_TOPIC_SIZE;
                        n_topic_size = {i_byte, 8'd0};
                        n_phase      = PH_TLEN_LO;
                    end
                    PH_TLEN_LO: begin
                        o_result.byte_role = ROLE_TOPIC_SIZE;
                        n_topic_size = {r_topic_size[15:8], i_byte};
                        n_topic_left = n_topic_size;
                        if ({12'd0, n_topic_size} > body_rem) begin
                            n_bad = 1'b1;
                        end
                        n_phase = (n_topic_size != '0) ? PH_TOPIC : PH_PAYLOAD;
                    end
                    PH_TOPIC: begin
                        o_result.byte_role = ROLE_TOPIC;
                        n_topic_left = (r_topic_left != '0) ? r_topic_left - 16'd1 : '0;
                        if (n_topic_left == '0) begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_result.byte_role = ROLE_PAYLOAD;
                    end
                    default: begin
                        o_result.byte_role = ROLE_OTHER;
                    end
                endcase
                if (body_rem == '0) begin
                    o_result.publish_valid = (r_kind == KIND_PUBLISH) &&
                        (r_phase == PH_TLEN_LO || r_phase == PH_TOPIC ||
                         r_phase == PH_PAYLOAD) && !n_bad && !over_now;
                    n_phase = PH_TYPE;
                end
            end
            default: begin
                // type byte, also taken for the unused phase code
                o_result.first_of_packet = 1'b1;
                n_kind       = i_byte[7:4];
                n_accum      = '0;
                n_len_cnt    = '0;
                n_body_left  = '0;
                n_topic_size = '0;
                n_topic_left = '0;
                n_bad        = 1'b0;
                n_phase      = PH_LEN;
            end
        endcase

        o_result.packet_kind = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_kind       <= '0;
            r_accum      <= '0;
            r_len_cnt    <= '0;
            r_body_left  <= '0;
            r_topic_size <= '0;
            r_topic_left <= '0;
            r_bad        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_accum      <= n_accum;
            r_len_cnt    <= n_len_cnt;
            r_body_left  <= n_body_left;
            r_topic_size <= n_topic_size;
            r_topic_left <= n_topic_left;
            r_bad        <= n_bad;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mqtt_packet_deframer.sv
// ---------------------------------------------------------------------------
// mqtt_packet_deframer
// tags each received mqtt 3.1.1 byte with its role inside the packet
// ---------------------------------------------------------------------------
// every byte taken on the slave side gives exactly one word on the master
// side through the output register: the byte itself, its role (type,
// length, topic length, topic, payload, other body), the packet's type
// nibble, start and end markers, a well-formed publish flag on the last
// byte and an oversize flag. the parser decides everything for a byte in
// the cycle it arrives, so a byte can be taken every clock; the output
// register plus one skid word let the input take one more byte after the
// sink stalls, and s_axis_tready drops only while the skid word is full.
// max_body_length is written through i_cfg_we/i_cfg_wdata; a write
// counts for every byte taken after it, also inside a packet.
`default_nettype none

module mqtt_packet_deframer import mpd_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // config: max_body_length
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_wdata,
    // input bytes
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    // tagged bytes
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] data_byte
    output logic                  m_axis_tlast,   // last_of_packet
    // [2:0] byte_role, [6:3] packet_kind, [7] first_of_packet,
    // [8] publish_valid, [9] oversize
    output logic [9:0]            m_axis_tuser
);

    logic [LEN_W-1:0] r_max_body;
    t_result          new_result;

    logic    in_accept;
    logic    out_take;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            r_max_body <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    mpd_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_byte            (s_axis_tdata),
        .i_max_body_length (r_max_body),
        .o_result          (new_result)
    );

    // output word plus skid word
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take) begin
            if (r_skid_valid) begin
                // skid full means no accept this cycle
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out = new_result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid) begin
                n_out       = new_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = new_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data_byte;
    assign m_axis_tlast  = r_out.last_of_packet;
    assign m_axis_tuser  = {r_out.oversize, r_out.publish_valid, r_out.first_of_packet,
                            r_out.packet_kind, r_out.byte_role};

endmodule

`default_nettype wire

### hw/rtl/mpd_checker.sv
// ---------------------------------------------------------------------------
// mpd_checker
// port-level checks on the deframer output stream, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mpd_checker import mpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic [9:0]  m_axis_tuser
);

    // stalled word holds
    `AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}))

    // input only backs up when a word is waiting
    `AST_SAME(a_ready_low_has_word, !s_axis_tready, m_axis_tvalid)

    // a good publish is flagged only on its last byte, never when oversize
    `AST_SAME(a_publish_on_last, m_axis_tvalid && m_axis_tuser[8],
              m_axis_tlast && !m_axis_tuser[9] && m_axis_tuser[6:3] == KIND_PUBLISH)

    // type byte carries the type role and never ends the packet
    `AST_SAME(a_first_is_type, m_axis_tvalid && m_axis_tuser[7],
              m_axis_tuser[2:0] == ROLE_TYPE && !m_axis_tlast && !m_axis_tuser[9])

    // a type byte cannot follow a type byte
    `AST_NEXT(a_no_double_type, m_axis_tvalid && m_axis_tready && m_axis_tuser[7],
              !(m_axis_tvalid && m_axis_tuser[7]))

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (.*);

`default_nettype wire
